>>> hw/rtl/ugbp_pkg.sv
// ugbp_pkg: shared types, codes and defaults of the uniform grid broad phase
// depends on nothing; imported by the front, the back, the top and the checker
package ugbp_pkg;

  localparam int DEF_MAX_OBJECTS = 32;
  localparam int DEF_CELL_SLOTS  = 8;
  localparam int DEF_MAX_COLS    = 16;
  localparam int DEF_MAX_ROWS    = 16;

  localparam int COORD_W   = 8;
  localparam int CSIZE_W   = 23;
  localparam int COUNT_W   = 5;
  localparam int CFG_IDX_W = 2;
  localparam int BOX_W     = 24;

  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd2;

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_QUERY  = 3'd2;
  localparam logic [2:0] OP_REGION = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_CELL_OVF = 3'd4;

  typedef struct packed {
    logic [2:0]              operation;
    logic [31:0]             object_id;
    logic signed [BOX_W-1:0] box_min_x;
    logic signed [BOX_W-1:0] box_min_y;
    logic signed [BOX_W-1:0] box_max_x;
    logic signed [BOX_W-1:0] box_max_y;
    logic [31:0]             layer_bits;
    logic [31:0]             mask_bits;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        hit_valid;
    logic [31:0] hit_id;
    logic        last;
  } out_item_t;

  // classified command handed from front to back
  typedef struct packed {
    logic [2:0]         op;
    logic [31:0]        object_id;
    logic [31:0]        layer_bits;
    logic [31:0]        mask_bits;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y1;
  } cmd_t;

  typedef struct packed {
    logic [31:0]        id;
    logic [31:0]        layer;
    logic [31:0]        mask;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y1;
  } slot_t;

  function automatic logic [COORD_W:0] eff_count(input logic [COUNT_W-1:0] r, input int mx);
    logic [COORD_W:0] v;
    if (r == '0) v = (COORD_W+1)'(1);
    else if (int'(r) > mx) v = (COORD_W+1)'(mx);
    else v = (COORD_W+1)'(r);
    return v;
  endfunction

endpackage

>>> hw/rtl/ugbp_ram.sv
// ugbp_ram: generic single write, single read memory with registered read
// depends on nothing
module ugbp_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/ugbp_queue.sv
// ugbp_queue: small register queue carrying packed payload bits
// depends on nothing
module ugbp_queue #(
  parameter int W = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int NW = $clog2(DEPTH + 1)
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         rd,
  output logic [W-1:0] rdata,
  output logic         empty
);

  logic [W-1:0]  buf_q [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [NW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full  = (count == NW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = buf_q[rptr];
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
    if (do_wr) begin
      buf_q[wptr] <= wdata;
    end
  end

endmodule

>>> hw/rtl/ugbp_front.sv
// ugbp_front: accepts items, holds the grid registers, maps box corners to cells
// depends on ugbp_pkg
module ugbp_front #(
  parameter int MAX_COLS = ugbp_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = ugbp_pkg::DEF_MAX_ROWS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  ugbp_pkg::in_item_t             item,
  output logic                           full,
  input  logic                           cfg_we,
  input  logic [ugbp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ugbp_pkg::CSIZE_W-1:0]   cfg_data,
  output logic                           cmd_push,
  output ugbp_pkg::cmd_t                 cmd,
  input  logic                           cmd_full
);
  import ugbp_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_t;

  fstate_t             st;
  in_item_t            itm;
  logic [CSIZE_W-1:0]  cell_size;
  logic [COUNT_W-1:0]  grid_cols;
  logic [COUNT_W-1:0]  grid_rows;
  logic [CSIZE_W-1:0]  cs;
  logic [4:0]          step;
  logic [CSIZE_W-1:0]  dvd [4];
  logic [CSIZE_W-1:0]  rem [4];
  logic [CSIZE_W-1:0]  quo [4];
  logic [3:0]          neg;
  logic [CSIZE_W-1:0]  dvd_next [4];
  logic [CSIZE_W-1:0]  rem_next [4];
  logic [CSIZE_W-1:0]  quo_next [4];
  logic [CSIZE_W:0]    rsh [4];
  logic [COORD_W-1:0]  lim_x;
  logic [COORD_W-1:0]  lim_y;
  logic [COORD_W-1:0]  cell_idx [4];
  logic [BOX_W-1:0]    corner [4];
  logic [COORD_W:0]    cols_eff;
  logic [COORD_W:0]    rows_eff;

  assign full = (st != F_IDLE);
  assign corner[0] = item.box_min_x;
  assign corner[1] = item.box_min_y;
  assign corner[2] = item.box_max_x;
  assign corner[3] = item.box_max_y;

  assign cols_eff = eff_count(grid_cols, MAX_COLS);
  assign rows_eff = eff_count(grid_rows, MAX_ROWS);
  assign lim_x = COORD_W'(cols_eff - 1'b1);
  assign lim_y = COORD_W'(rows_eff - 1'b1);

  // one restoring divide step per lane and cycle
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rsh[k] = {rem[k], dvd[k][CSIZE_W-1]};
      if (rsh[k] >= {1'b0, cs}) begin
        rem_next[k] = CSIZE_W'(rsh[k] - {1'b0, cs});
        quo_next[k] = {quo[k][CSIZE_W-2:0], 1'b1};
      end else begin
        rem_next[k] = CSIZE_W'(rsh[k]);
        quo_next[k] = {quo[k][CSIZE_W-2:0], 1'b0};
      end
      dvd_next[k] = {dvd[k][CSIZE_W-2:0], 1'b0};
    end
    for (int k = 0; k < 4; k++) begin
      if (neg[k]) begin
        cell_idx[k] = '0;
      end else if (k % 2 == 0) begin
        cell_idx[k] = (quo[k] > CSIZE_W'(lim_x)) ? lim_x : COORD_W'(quo[k]);
      end else begin
        cell_idx[k] = (quo[k] > CSIZE_W'(lim_y)) ? lim_y : COORD_W'(quo[k]);
      end
    end
    cmd.op         = itm.operation;
    cmd.object_id  = itm.object_id;
    cmd.layer_bits = itm.layer_bits;
    cmd.mask_bits  = itm.mask_bits;
    cmd.x0         = cell_idx[0];
    cmd.y0         = cell_idx[1];
    cmd.x1         = cell_idx[2];
    cmd.y1         = cell_idx[3];
  end

  assign cmd_push = (st == F_PUSH);

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= F_IDLE;
      cell_size <= CSIZE_W'(8192);
      grid_cols <= COUNT_W'(16);
      grid_rows <= COUNT_W'(16);
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CELL_SIZE: cell_size <= cfg_data;
          REG_GRID_COLS: grid_cols <= cfg_data[COUNT_W-1:0];
          REG_GRID_ROWS: grid_rows <= cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      unique case (st)
        F_IDLE: begin
          if (push) begin
            itm  <= item;
            cs   <= (cell_size == '0) ? CSIZE_W'(1) : cell_size;
            step <= '0;
            for (int k = 0; k < 4; k++) begin
              neg[k] <= corner[k][BOX_W-1];
              dvd[k] <= corner[k][CSIZE_W-1:0];
              rem[k] <= '0;
              quo[k] <= '0;
            end
            st <= F_DIV;
          end
        end
        F_DIV: begin
          for (int k = 0; k < 4; k++) begin
            dvd[k] <= dvd_next[k];
            rem[k] <= rem_next[k];
            quo[k] <= quo_next[k];
          end
          step <= step + 1'b1;
          if (step == 5'(CSIZE_W - 1)) begin
            st <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!cmd_full) begin
            st <= F_IDLE;
          end
        end
        default: st <= F_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/ugbp_back.sv
// ugbp_back: slot store, cell lists and the sequencer for add, remove, clear and queries
// depends on ugbp_pkg and ugbp_ram
module ugbp_back #(
  parameter int MAX_OBJECTS = ugbp_pkg::DEF_MAX_OBJECTS,
  parameter int CELL_SLOTS  = ugbp_pkg::DEF_CELL_SLOTS,
  parameter int MAX_COLS    = ugbp_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS    = ugbp_pkg::DEF_MAX_ROWS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  ugbp_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  output logic                res_push,
  output ugbp_pkg::out_item_t res,
  input  logic                res_full
);
  import ugbp_pkg::*;

  localparam int SW        = $clog2(MAX_OBJECTS);
  localparam int FW        = $clog2(CELL_SLOTS + 1);
  localparam int NUM_CELLS = MAX_COLS * MAX_ROWS;
  localparam int CAW       = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int NUM_ENT   = NUM_CELLS * CELL_SLOTS;
  localparam int EAW       = (NUM_ENT > 1) ? $clog2(NUM_ENT) : 1;
  localparam int SLW       = $bits(slot_t);

  typedef enum logic [3:0] {
    B_IDLE, B_SCAN_RD, B_SCAN_CMP, B_ADD_RD, B_ADD_WR, B_PRG_FILL, B_PRG_N,
    B_PRG_RD, B_PRG_WR, B_Q_FILL, B_Q_N, B_Q_RD, B_Q_SLOT, B_Q_CHK, B_Q_END, B_RESP
  } bstate_t;

  bstate_t             st;
  cmd_t                c;
  logic [SW-1:0]       scnt;
  logic [SW-1:0]       free_s;
  logic                free_ok;
  logic [SW-1:0]       ms;
  logic [2:0]          status;
  logic [COORD_W-1:0]  rx0, ry0, rx1, ry1, cx, cy;
  logic [FW-1:0]       i, j, n;
  logic [MAX_OBJECTS-1:0] valid;
  logic [MAX_OBJECTS-1:0] seen;
  logic [NUM_CELLS-1:0]   fvalid;
  logic                pend_ok;
  logic [31:0]         pend_id;
  logic [SW-1:0]       qs;
  logic                qs_ok;

  logic                s_we, s_re;
  logic [SW-1:0]       s_waddr, s_raddr;
  slot_t               s_wdata, s_rdata;
  logic                f_we, f_re;
  logic [CAW-1:0]      f_waddr;
  logic [FW-1:0]       f_wdata, f_rdata;
  logic                e_we, e_re;
  logic [EAW-1:0]      e_waddr, e_raddr;
  logic [SW-1:0]       e_wdata, e_rdata;

  logic [CAW-1:0]      ca;
  logic [FW-1:0]       f;
  logic                cell_done;
  logic                slot_last;
  logic                id_hit;
  logic                have_free;
  logic [SW-1:0]       new_s;
  logic                do_alloc;
  logic                keep;
  logic [FW-1:0]       j_inc;
  logic                cand;
  logic                pass;
  logic                hitq;
  logic                q_stall;
  logic                is_add;

  ugbp_ram #(.W(SLW), .D(MAX_OBJECTS)) u_slot_ram (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .re(s_re), .raddr(s_raddr), .rdata(s_rdata)
  );
  ugbp_ram #(.W(FW), .D(NUM_CELLS)) u_fill_ram (
    .clk, .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .re(f_re), .raddr(ca), .rdata(f_rdata)
  );
  ugbp_ram #(.W(SW), .D(NUM_ENT)) u_entry_ram (
    .clk, .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .re(e_re), .raddr(e_raddr), .rdata(e_rdata)
  );

  assign ca        = CAW'(int'(cy) * MAX_COLS + int'(cx));
  assign f         = fvalid[ca] ? f_rdata : '0;
  assign cell_done = (cx == rx1) && (cy == ry1);
  assign slot_last = (scnt == SW'(MAX_OBJECTS - 1));
  assign is_add    = (c.op == OP_ADD);
  assign id_hit    = valid[scnt] && (s_rdata.id == c.object_id);
  assign have_free = free_ok || !valid[scnt];
  assign new_s     = free_ok ? free_s : scnt;
  assign do_alloc  = (st == B_SCAN_CMP) && is_add && !id_hit && slot_last && have_free;
  assign keep      = (e_rdata != ms);
  assign j_inc     = keep ? j + 1'b1 : j;
  assign cand      = qs_ok && valid[qs] && !seen[qs];
  assign pass      = (c.op == OP_REGION) ||
                     (((c.layer_bits & s_rdata.mask) != '0) &&
                      ((s_rdata.layer & c.mask_bits) != '0));
  assign hitq      = cand && pass;
  assign q_stall   = hitq && pend_ok && res_full;

  always_comb begin
    s_we    = do_alloc;
    s_waddr = new_s;
    s_wdata = '{id: c.object_id, layer: c.layer_bits, mask: c.mask_bits,
                x0: c.x0, y0: c.y0, x1: c.x1, y1: c.y1};
    s_re    = 1'b0;
    s_raddr = scnt;
    f_we    = 1'b0;
    f_waddr = ca;
    f_wdata = '0;
    f_re    = (st == B_ADD_RD) || (st == B_PRG_FILL) || (st == B_Q_FILL);
    e_we    = 1'b0;
    e_waddr = EAW'(int'(ca) * CELL_SLOTS + int'(f));
    e_wdata = ms;
    e_re    = (st == B_PRG_RD) || (st == B_Q_RD);
    e_raddr = EAW'(int'(ca) * CELL_SLOTS + int'(i));
    cmd_pop  = 1'b0;
    res_push = 1'b0;
    res      = '{status: status, hit_valid: 1'b0, hit_id: '0, last: 1'b1};
    unique case (st)
      B_IDLE:    cmd_pop = cmd_valid;
      B_SCAN_RD: s_re = 1'b1;
      B_ADD_WR: begin
        if (f < FW'(CELL_SLOTS)) begin
          e_we    = 1'b1;
          f_we    = 1'b1;
          f_wdata = f + 1'b1;
        end
      end
      B_PRG_WR: begin
        e_we    = keep;
        e_waddr = EAW'(int'(ca) * CELL_SLOTS + int'(j));
        e_wdata = e_rdata;
        f_we    = (i + 1'b1 == n);
        f_wdata = j_inc;
      end
      B_Q_SLOT: begin
        s_re    = 1'b1;
        s_raddr = e_rdata;
      end
      B_Q_CHK: begin
        if (hitq && pend_ok && !res_full) begin
          res_push = 1'b1;
          res      = '{status: ST_OK, hit_valid: 1'b1, hit_id: pend_id, last: 1'b0};
        end
      end
      B_Q_END: begin
        res_push = !res_full;
        res      = '{status: ST_OK, hit_valid: pend_ok,
                     hit_id: pend_ok ? pend_id : '0, last: 1'b1};
      end
      B_RESP:  res_push = !res_full;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= B_IDLE;
      valid   <= '0;
      fvalid  <= '0;
      seen    <= '0;
      pend_ok <= 1'b0;
      free_ok <= 1'b0;
    end else begin
      unique case (st)
        B_IDLE: begin
          if (cmd_valid) begin
            c      <= cmd;
            status <= ST_OK;
            rx0 <= cmd.x0;
            ry0 <= cmd.y0;
            rx1 <= cmd.x1;
            ry1 <= cmd.y1;
            cx  <= cmd.x0;
            cy  <= cmd.y0;
            case (cmd.op) inside
              OP_ADD, OP_REMOVE: begin
                scnt    <= '0;
                free_ok <= 1'b0;
                st      <= B_SCAN_RD;
              end
              OP_QUERY, OP_REGION: begin
                seen    <= '0;
                pend_ok <= 1'b0;
                st <= ((cmd.x0 > cmd.x1) || (cmd.y0 > cmd.y1)) ? B_Q_END : B_Q_FILL;
              end
              OP_CLEAR: begin
                valid  <= '0;
                fvalid <= '0;
                seen   <= '0;
                st     <= B_RESP;
              end
              default: st <= B_RESP;
            endcase
          end
        end
        B_SCAN_RD: st <= B_SCAN_CMP;
        B_SCAN_CMP: begin
          if (!valid[scnt] && !free_ok) begin
            free_s  <= scnt;
            free_ok <= 1'b1;
          end
          if (id_hit) begin
            ms <= scnt;
            if (is_add) begin
              status <= ST_DUP;
              st     <= B_RESP;
            end else begin
              rx0 <= s_rdata.x0;
              ry0 <= s_rdata.y0;
              rx1 <= s_rdata.x1;
              ry1 <= s_rdata.y1;
              cx  <= s_rdata.x0;
              cy  <= s_rdata.y0;
              if ((s_rdata.x0 > s_rdata.x1) || (s_rdata.y0 > s_rdata.y1)) begin
                valid[scnt] <= 1'b0;
                st <= B_RESP;
              end else begin
                st <= B_PRG_FILL;
              end
            end
          end else if (slot_last) begin
            if (!is_add) begin
              status <= ST_NOTFOUND;
              st     <= B_RESP;
            end else if (!have_free) begin
              status <= ST_FULL;
              st     <= B_RESP;
            end else begin
              valid[new_s] <= 1'b1;
              ms <= new_s;
              st <= ((c.x0 > c.x1) || (c.y0 > c.y1)) ? B_RESP : B_ADD_RD;
            end
          end else begin
            scnt <= scnt + 1'b1;
            st   <= B_SCAN_RD;
          end
        end
        B_ADD_RD: st <= B_ADD_WR;
        B_ADD_WR: begin
          if (f < FW'(CELL_SLOTS)) begin
            fvalid[ca] <= 1'b1;
          end else begin
            status <= ST_CELL_OVF;
          end
          if (cx == rx1) begin
            cx <= rx0;
            cy <= cy + 1'b1;
          end else begin
            cx <= cx + 1'b1;
          end
          st <= cell_done ? B_RESP : B_ADD_RD;
        end
        B_PRG_FILL: st <= B_PRG_N;
        B_PRG_N: begin
          n <= f;
          i <= '0;
          j <= '0;
          if (f == '0) begin
            if (cx == rx1) begin
              cx <= rx0;
              cy <= cy + 1'b1;
            end else begin
              cx <= cx + 1'b1;
            end
            if (cell_done) begin
              valid[ms] <= 1'b0;
              st <= B_RESP;
            end else begin
              st <= B_PRG_FILL;
            end
          end else begin
            st <= B_PRG_RD;
          end
        end
        B_PRG_RD: st <= B_PRG_WR;
        B_PRG_WR: begin
          j <= j_inc;
          i <= i + 1'b1;
          if (i + 1'b1 == n) begin
            fvalid[ca] <= 1'b1;
            if (cx == rx1) begin
              cx <= rx0;
              cy <= cy + 1'b1;
            end else begin
              cx <= cx + 1'b1;
            end
            if (cell_done) begin
              valid[ms] <= 1'b0;
              st <= B_RESP;
            end else begin
              st <= B_PRG_FILL;
            end
          end else begin
            st <= B_PRG_RD;
          end
        end
        B_Q_FILL: st <= B_Q_N;
        B_Q_N: begin
          n <= f;
          i <= '0;
          if (f == '0) begin
            if (cx == rx1) begin
              cx <= rx0;
              cy <= cy + 1'b1;
            end else begin
              cx <= cx + 1'b1;
            end
            st <= cell_done ? B_Q_END : B_Q_FILL;
          end else begin
            st <= B_Q_RD;
          end
        end
        B_Q_RD: st <= B_Q_SLOT;
        B_Q_SLOT: begin
          qs    <= e_rdata;
          qs_ok <= (int'(e_rdata) < MAX_OBJECTS);
          st    <= B_Q_CHK;
        end
        B_Q_CHK: begin
          if (!q_stall) begin
            if (cand) begin
              seen[qs] <= 1'b1;
            end
            // hold back each hit until the next one shows whether it is the final one
            if (hitq) begin
              pend_ok <= 1'b1;
              pend_id <= s_rdata.id;
            end
            i <= i + 1'b1;
            if (i + 1'b1 == n) begin
              if (cx == rx1) begin
                cx <= rx0;
                cy <= cy + 1'b1;
              end else begin
                cx <= cx + 1'b1;
              end
              st <= cell_done ? B_Q_END : B_Q_FILL;
            end else begin
              st <= B_Q_RD;
            end
          end
        end
        B_Q_END: begin
          if (!res_full) begin
            seen <= '0;
            st   <= B_IDLE;
          end
        end
        B_RESP: begin
          if (!res_full) begin
            st <= B_IDLE;
          end
        end
        default: st <= B_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/uniform_grid_broad_phase.sv
// Uniform grid broad phase. Items enter through push/full and results leave through
// empty/pop. The front maps the four box corners to cells with a radix-2 divider by
// cell_size in 23 divide steps; full stays high from each transfer until the command
// is written into a two-entry queue to the back. The back scans the slot memory slot
// by slot for add and remove, with a read and a compare per slot, stopping at a matching
// id. An add reads the fill count of each covered cell and writes the entry; a remove
// reads each cell's count, then reads and rewrites each stored entry; a query reads each
// cell's count, then each entry and its slot. Results pass through a two-entry queue, so
// the back keeps working while one waits to be popped. There is no clearing pass on reset.
// depends on ugbp_pkg, ugbp_front, ugbp_queue, ugbp_back
module uniform_grid_broad_phase #(
  parameter int MAX_OBJECTS = ugbp_pkg::DEF_MAX_OBJECTS,
  parameter int CELL_SLOTS  = ugbp_pkg::DEF_CELL_SLOTS,
  parameter int MAX_COLS    = ugbp_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS    = ugbp_pkg::DEF_MAX_ROWS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  ugbp_pkg::in_item_t             item,
  output logic                           full,
  output logic                           empty,
  input  logic                           pop,
  output ugbp_pkg::out_item_t            result,
  input  logic                           cfg_we,
  input  logic [ugbp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ugbp_pkg::CSIZE_W-1:0]   cfg_data
);
  import ugbp_pkg::*;

  logic      cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_t      cmd_in, cmd_out;
  logic      res_push, res_full;
  out_item_t res_in;

  ugbp_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_front (
    .clk, .rst, .push, .item, .full, .cfg_we, .cfg_index, .cfg_data,
    .cmd_push, .cmd(cmd_in), .cmd_full
  );

  ugbp_queue #(.W($bits(cmd_t)), .DEPTH(2)) u_cmd_q (
    .clk, .rst, .wr(cmd_push), .wdata(cmd_in), .full(cmd_full),
    .rd(cmd_pop), .rdata(cmd_out), .empty(cmd_empty)
  );

  ugbp_back #(
    .MAX_OBJECTS(MAX_OBJECTS), .CELL_SLOTS(CELL_SLOTS),
    .MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)
  ) u_back (
    .clk, .rst, .cmd_valid(!cmd_empty), .cmd(cmd_out), .cmd_pop,
    .res_push, .res(res_in), .res_full
  );

  ugbp_queue #(.W($bits(out_item_t)), .DEPTH(2)) u_res_q (
    .clk, .rst, .wr(res_push), .wdata(res_in), .full(res_full),
    .rd(pop), .rdata(result), .empty
  );

endmodule

>>> hw/rtl/ugbp_checker.sv
// ugbp_sva: port-level checks of the uniform grid broad phase, bound to the top
// depends on ugbp_pkg and uniform_grid_broad_phase
module ugbp_sva (
  input logic                           clk,
  input logic                           rst,
  input logic                           push,
  input ugbp_pkg::in_item_t             item,
  input logic                           full,
  input logic                           empty,
  input logic                           pop,
  input ugbp_pkg::out_item_t            result,
  input logic                           cfg_we,
  input logic [ugbp_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [ugbp_pkg::CSIZE_W-1:0]   cfg_data
);
  import ugbp_pkg::*;

  // nothing waits to be taken right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // an accepted item keeps the front busy on the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst) (push && !full) |=> full)
    else $error("front took a second item back to back");

  // a result without a hit always closes its item
  a_nohit_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.hit_valid) |-> result.last)
    else $error("result without a hit is not the final one");

  a_nohit_id: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.hit_valid) |-> (result.hit_id == '0))
    else $error("id shown without a hit");

  a_hit_ok: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.hit_valid) |-> (result.status == ST_OK))
    else $error("hit carries an error status");

endmodule

bind uniform_grid_broad_phase ugbp_sva u_ugbp_sva (.*);
